### hdl/ptes_pkg.sv
// ----------------------------------------------------------------------------
// ptes_pkg: shared types and constants of the timed event scheduler
// Holds the request and response word layouts, command codes, priority level
// codes and the default sizing of the slot bank.
// ----------------------------------------------------------------------------
package ptes_pkg;

	// Default sizing, handed to the top level parameters.
	localparam int SlotCountDef = 8;
	localparam int TimeBitsDef  = 48;

	// Fixed field widths of the request and response words.
	localparam int LevelW = 3;
	localparam int DelayW = 32;
	localparam int InfoW  = 16;
	localparam int NowW   = 48;

	// Command codes.
	localparam logic CMD_ARM  = 1'b0;
	localparam logic CMD_FIRE = 1'b1;

	// CPU priority levels up to this one let every slot fire.
	localparam logic [LevelW-1:0] LEVEL_ALL_MAX = 3'd3;
	// At this level only slot 0 may fire; above it no slot fires.
	localparam logic [LevelW-1:0] LEVEL_SLOT0   = 3'd4;

	// One request word.
	typedef struct packed {
		logic              cmd;
		logic [LevelW-1:0] priority_level;
		logic [DelayW-1:0] delay_ticks;
		logic [InfoW-1:0]  event_info;
		logic [NowW-1:0]   now_ticks;
	} req_word_t;

	// One response word.
	typedef struct packed {
		logic              fired;
		logic [LevelW-1:0] fired_slot;
		logic [InfoW-1:0]  fired_info;
		logic              rejected;
	} rsp_word_t;

	// Decoded operation handed to the slot bank.
	typedef struct packed {
		logic              arm;
		logic              fire;
		logic [LevelW-1:0] level;
	} slot_op_t;

endpackage

### hdl/priority_timed_event_scheduler.sv
// ----------------------------------------------------------------------------
// priority_timed_event_scheduler: per-priority timed event slots
// Arms event slots with a saturating due time and releases the lowest
// pending, allowed and due slot for a given CPU priority level.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on req (req_valid / req_ready); a word with cmd = CMD_ARM
// arms the slot named by priority_level at now_ticks + delay_ticks, and a
// word with cmd = CMD_FIRE releases at most one slot allowed at that CPU
// priority level. Every request gives exactly one response word on rsp
// (rsp_valid / rsp_ready), in request order.
// The input register takes the word at the accepting edge, and the slot
// update and result register follow once the response register is free.
// One word per cycle is accepted while the receiver keeps rsp_ready high;
// the slot compares, priority pick and due-time adder all sit in the single
// stage between those two registers.
// A stalled receiver holds the response register; one more request can
// wait in the input register, after which req_ready drops until rsp drains.
// Reset clears all pending bits and both valid flags; due times and info
// words hold no meaning until their slot is armed.
// ----------------------------------------------------------------------------
module priority_timed_event_scheduler #(
	parameter int SLOT_COUNT = ptes_pkg::SlotCountDef,
	parameter int TIME_BITS  = ptes_pkg::TimeBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ptes_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ptes_pkg::rsp_word_t rsp
);

	ptes_pkg::req_word_t  req_s1;
	logic                 valid_s1;
	ptes_pkg::rsp_word_t  rsp_q;
	logic                 rsp_valid_q;

	logic                 advance;
	ptes_pkg::slot_op_t   op;
	ptes_pkg::rsp_word_t  rsp_d;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] due_t;

	// Handshake: the held word moves on when the response register is free.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// Decode of the held word.
	always_comb begin
		op.arm   = valid_s1 && (req_s1.cmd == ptes_pkg::CMD_ARM);
		op.fire  = valid_s1 && (req_s1.cmd == ptes_pkg::CMD_FIRE);
		op.level = req_s1.priority_level;
	end

	ptes_due_calc #(
		.TIME_BITS(TIME_BITS)
	) u_due_calc (
		.now_ticks  (req_s1.now_ticks),
		.delay_ticks(req_s1.delay_ticks),
		.now_t      (now_t),
		.due_t      (due_t)
	);

	ptes_slot_bank #(
		.SLOT_COUNT(SLOT_COUNT),
		.TIME_BITS (TIME_BITS)
	) u_slot_bank (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (op),
		.commit(advance),
		.now_t (now_t),
		.due_t (due_t),
		.info  (req_s1.event_info),
		.rsp   (rsp_d)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

### hdl/ptes_due_calc.sv
// ----------------------------------------------------------------------------
// ptes_due_calc: due time adder
// Reduces the current time to the time width and adds the delay, saturating
// the due time at the largest representable time.
// ----------------------------------------------------------------------------
module ptes_due_calc #(
	parameter int TIME_BITS = ptes_pkg::TimeBitsDef
) (
	input  logic [ptes_pkg::NowW-1:0]   now_ticks,
	input  logic [ptes_pkg::DelayW-1:0] delay_ticks,
	output logic [TIME_BITS-1:0]        now_t,
	output logic [TIME_BITS-1:0]        due_t
);

	localparam int SumW = ((TIME_BITS > ptes_pkg::DelayW) ? TIME_BITS : ptes_pkg::DelayW) + 1;

	logic [SumW-1:0] sum;
	logic            overflow;

	// Current time taken modulo the time width.
	assign now_t = TIME_BITS'(now_ticks);

	// Full-width sum; any bit at or above the time width means saturation.
	assign sum      = SumW'(now_t) + SumW'(delay_ticks);
	assign overflow = |sum[SumW-1:TIME_BITS];
	assign due_t    = overflow ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

endmodule

### hdl/ptes_slot_bank.sv
// ----------------------------------------------------------------------------
// ptes_slot_bank: event slots and release logic
// Holds the pending bits, due times and info words of all slots, forms the
// response for the operation in flight and updates the slots on commit.
// ----------------------------------------------------------------------------
module ptes_slot_bank #(
	parameter int SLOT_COUNT = ptes_pkg::SlotCountDef,
	parameter int TIME_BITS  = ptes_pkg::TimeBitsDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptes_pkg::slot_op_t             op,
	input  logic                           commit,
	input  logic [TIME_BITS-1:0]           now_t,
	input  logic [TIME_BITS-1:0]           due_t,
	input  logic [ptes_pkg::InfoW-1:0]     info,
	output ptes_pkg::rsp_word_t            rsp
);

	localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [SLOT_COUNT-1:0]          pending_q;
	logic [TIME_BITS-1:0]           due_q  [SLOT_COUNT];
	logic [ptes_pkg::InfoW-1:0]     info_q [SLOT_COUNT];

	logic                           slot_ok;
	logic [SlotW-1:0]               slot_idx;
	logic                           slot_busy;
	logic                           arm_ok;
	logic [SLOT_COUNT-1:0]          allowed;
	logic [SLOT_COUNT-1:0]          cand;
	logic [SLOT_COUNT-1:0]          first_hot;
	logic                           hit;
	logic [SlotW-1:0]               hit_idx;
	logic [ptes_pkg::InfoW-1:0]     hit_info;

	// Register side: the named slot must exist and be free.
	assign slot_ok   = 32'(op.level) < 32'(SLOT_COUNT);
	assign slot_idx  = SlotW'(op.level);
	assign slot_busy = slot_ok && pending_q[slot_idx];
	assign arm_ok    = op.arm && slot_ok && !pending_q[slot_idx];

	// Fire side: level mask, then the slots that are pending and due.
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (op.level <= ptes_pkg::LEVEL_ALL_MAX) begin
				allowed[i] = 1'b1;
			end else if (op.level == ptes_pkg::LEVEL_SLOT0) begin
				allowed[i] = (i == 0);
			end else begin
				allowed[i] = 1'b0;
			end
			cand[i] = allowed[i] && pending_q[i] && (now_t >= due_q[i]);
		end
	end

	// Lowest candidate as a one-hot vector, then an AND-OR select.
	assign first_hot = cand & (~cand + SLOT_COUNT'(1));
	assign hit       = op.fire && (|cand);

	always_comb begin
		hit_idx  = '0;
		hit_info = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (first_hot[i]) begin
				hit_idx  = hit_idx | SlotW'(i);
				hit_info = hit_info | info_q[i];
			end
		end
	end

	// Response word for the operation in flight.
	always_comb begin
		rsp.fired      = hit;
		rsp.fired_slot = hit ? ptes_pkg::LevelW'(hit_idx) : '0;
		rsp.fired_info = hit ? hit_info : '0;
		rsp.rejected   = op.arm && slot_busy;
	end

	// Pending bits: set on a successful arm, cleared on a release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (commit) begin
			if (arm_ok) begin
				pending_q[slot_idx] <= 1'b1;
			end else if (hit) begin
				pending_q <= pending_q & ~first_hot;
			end
		end
	end

	// Slot payload, written only when a slot is armed.
	always_ff @(posedge clk) begin
		if (commit && arm_ok) begin
			due_q[slot_idx]  <= due_t;
			info_q[slot_idx] <= info;
		end
	end

endmodule

### tb/sv/priority_timed_event_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_timed_event_scheduler_tb: self-checking bench for the event scheduler
// Walks a short table of arm and fire words through the block, then several
// hundred random ones over a moving clock time. A local copy of the slot bank
// predicts every response word that the table does not type in by hand.
// Sender gaps and receiver stalls vary by phase.
module priority_timed_event_scheduler_tb;

	localparam int SlotCount = ptes_pkg::SlotCountDef;
	localparam int TimeBits  = ptes_pkg::TimeBitsDef;
	localparam logic [TimeBits-1:0] NowMax = '1;
	localparam int RandPerPhase = 100;

	// One row of the directed table: the request word and, where it is obvious,
	// the response word typed in by hand.
	typedef struct {
		ptes_pkg::req_word_t w;
		bit                  typed;
		ptes_pkg::rsp_word_t want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	ptes_pkg::req_word_t req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	ptes_pkg::rsp_word_t rsp;

	// Local copy of the slot bank.
	logic [SlotCount-1:0]       armed_bits;
	logic [TimeBits-1:0]        armed_due [SlotCount];
	logic [ptes_pkg::InfoW-1:0] armed_info [SlotCount];

	ptes_pkg::rsp_word_t sched_rsp_q [$];
	dir_row_t            dir_table [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int fire_seen = 0;
	int reject_seen = 0;
	ptes_pkg::rsp_word_t want;

	priority_timed_event_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Applies one word to the local slot bank and returns the response it gives.
	function automatic ptes_pkg::rsp_word_t scheduler_step(input ptes_pkg::req_word_t w);
		ptes_pkg::rsp_word_t  r;
		logic [TimeBits:0]    sum;
		logic [SlotCount-1:0] allowed;
		bit                   done;
		r = '0;
		done = 1'b0;
		if (w.cmd == ptes_pkg::CMD_ARM) begin
			if (armed_bits[w.priority_level]) begin
				r.rejected = 1'b1;
			end else begin
				sum = {1'b0, w.now_ticks} +
					{{(TimeBits + 1 - ptes_pkg::DelayW){1'b0}}, w.delay_ticks};
				armed_due[w.priority_level] = sum[TimeBits] ? NowMax : sum[TimeBits-1:0];
				armed_info[w.priority_level] = w.event_info;
				armed_bits[w.priority_level] = 1'b1;
			end
		end else begin
			if (w.priority_level <= ptes_pkg::LEVEL_ALL_MAX)
				allowed = armed_bits;
			else if (w.priority_level == ptes_pkg::LEVEL_SLOT0)
				allowed = armed_bits & SlotCount'(1);
			else
				allowed = '0;
			// Lowest allowed slot that is due wins.
			for (int s = 0; s < SlotCount; s++) begin
				if (!done && allowed[s] && w.now_ticks >= armed_due[s]) begin
					armed_bits[s] = 1'b0;
					r.fired = 1'b1;
					r.fired_slot = ptes_pkg::LevelW'(s);
					r.fired_info = armed_info[s];
					done = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic dir_row_t dir_row(input logic cmd,
			input logic [ptes_pkg::LevelW-1:0] lvl,
			input logic [ptes_pkg::DelayW-1:0] dly,
			input logic [ptes_pkg::InfoW-1:0] info,
			input logic [ptes_pkg::NowW-1:0] now, input bit typed, input logic fired,
			input logic [ptes_pkg::LevelW-1:0] slot,
			input logic [ptes_pkg::InfoW-1:0] finfo,
			input logic rej);
		dir_row_t d;
		d.w = '{cmd: cmd, priority_level: lvl, delay_ticks: dly, event_info: info,
			now_ticks: now};
		d.typed = typed;
		d.want = '{fired: fired, fired_slot: slot, fired_info: finfo, rejected: rej};
		return d;
	endfunction

	// Drives one word after a random gap, waits for acceptance and queues the
	// hand-typed response, or else the one the local slot bank gives for it.
	task automatic send_word(input ptes_pkg::req_word_t w, input bit typed,
			input ptes_pkg::rsp_word_t typed_rsp);
		ptes_pkg::rsp_word_t model_rsp;
		model_rsp = scheduler_step(w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sched_rsp_q.push_back(typed ? typed_rsp : model_rsp);
		sent_count++;
	endtask

	// Response checker: every accepted word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			checked_count++;
			if (rsp.fired) fire_seen++;
			if (rsp.rejected) reject_seen++;
			if (sched_rsp_q.size() == 0) begin
				if (fail_count < 10)
					$display("ERROR: unexpected response word %p at %0t", rsp, $realtime);
				fail_count++;
			end else begin
				want = sched_rsp_q.pop_front();
				if (rsp.fired !== want.fired || rsp.fired_slot !== want.fired_slot ||
						rsp.fired_info !== want.fired_info ||
						rsp.rejected !== want.rejected) begin
					if (fail_count < 10)
						$display("ERROR: word %0d at %0t expected %p, got %p",
							checked_count, $realtime, want, rsp);
					fail_count++;
				end
			end
		end
	end

	// Main stimulus.
	initial begin
		ptes_pkg::req_word_t  w;
		logic [TimeBits-1:0]  cur_now;
		int                   pick;
		armed_bits = '0;
		for (int s = 0; s < SlotCount; s++) begin
			armed_due[s] = '0;
			armed_info[s] = '0;
		end

		// Directed table; hand-typed responses where they are plain to see.
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd0, 32'd0, 16'd0, 48'd0,
			1, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd0, 32'd0, 16'hFFFF, 48'd0,
			1, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd0, 32'd5, 16'd0, 48'd0,
			1, 0, 0, 0, 1));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd7, 32'd0, 16'd0, NowMax,
			1, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd5, 32'd0, 16'd0, NowMax,
			1, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd6, 32'd0, 16'd0, NowMax,
			1, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, ptes_pkg::LEVEL_SLOT0, 32'd0,
			16'd0, 48'd0, 1, 1, 0, 16'hFFFF, 0));
		// Due time saturates at the top of the time range.
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd7, 32'hFFFF_FFFF, 16'h8001,
			NowMax, 1, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, ptes_pkg::LEVEL_ALL_MAX, 32'd0,
			16'd0, NowMax - 1, 1, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, ptes_pkg::LEVEL_ALL_MAX, 32'd0,
			16'd0, NowMax, 1, 1, 3'd7, 16'h8001, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd3, 32'd100, 16'h1234, 48'd1000,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd5, 32'd0, 16'hA5A5, 48'd500,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, ptes_pkg::LEVEL_SLOT0, 32'd0,
			16'd0, 48'd2000, 0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd2, 32'd0, 16'd0, 48'd600,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd1, 32'd0, 16'd0, 48'd1100,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd1, 32'd0, 16'h0001, 48'd0,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd2, 32'd0, 16'h0002, 48'd0,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd0, 32'd0, 16'd0, 48'd0,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd0, 32'd0, 16'd0, 48'd0,
			0, 0, 0, 0, 0));
		// Sum landing exactly on the top, then one past it.
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd6, 32'h0000_FFFF, 16'h5A5A,
			48'hFFFF_FFFF_0000, 0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_ARM, 3'd4, 32'h0001_0000, 16'h0F0F,
			48'hFFFF_FFFF_0000, 0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, ptes_pkg::LEVEL_ALL_MAX, 32'd0,
			16'd0, NowMax - 1, 0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd0, 32'd0, 16'd0, NowMax,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd0, 32'd0, 16'd0, NowMax,
			0, 0, 0, 0, 0));
		dir_table.push_back(dir_row(ptes_pkg::CMD_FIRE, 3'd0, 32'd0, 16'd0, 48'd0,
			0, 0, 0, 0, 0));

		// Hold reset at the start, then release it.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_word(dir_table[i].w, dir_table[i].typed, dir_table[i].want);

		// Random words in four idling phases over a mostly rising clock time.
		cur_now = '0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 23; stall_pct = 23; end
			endcase
			for (int n = 0; n < RandPerPhase; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					cur_now = cur_now + TimeBits'($urandom_range(0, 20));
				else if (pick < 90)
					cur_now = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom())};
				else if (pick < 95)
					cur_now = NowMax;
				else
					cur_now = NowMax - TimeBits'($urandom_range(0, 64));
				w.cmd = $urandom_range(0, 1) ? ptes_pkg::CMD_FIRE : ptes_pkg::CMD_ARM;
				w.priority_level = ptes_pkg::LevelW'($urandom_range(0, 7));
				pick = $urandom_range(0, 99);
				if (pick < 70)
					w.delay_ticks = ptes_pkg::DelayW'($urandom_range(0, 40));
				else if (pick < 90)
					w.delay_ticks = $urandom();
				else
					w.delay_ticks = $urandom_range(0, 1) ? '1 : '0;
				w.event_info = ptes_pkg::InfoW'($urandom());
				w.now_ticks = cur_now;
				send_word(w, 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		// Drain, then wait for any stray response.
		while (sched_rsp_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d request words and checked %0d response words.",
			sent_count, checked_count);
		$display("Responses covered %0d releases and %0d rejected arms.",
			fire_seen, reject_seen);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches in total.", fail_count);
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("Timeout with %0d responses outstanding.", sched_rsp_q.size());
		$display("Verification failed");
		$finish;
	end

endmodule
